/* src/adw_pkg.sv */
`timescale 1ns / 1ps

package adw_pkg;

    // Field widths
    localparam int IDX_W      = 12;
    localparam int GRAD_W     = 32;
    localparam int AVG_W      = 48;
    localparam int DECAY_W    = 16;
    localparam int EPS_W      = 24;
    localparam int SCALE_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // One memory word holds both averages: {grad_sq, step_sq}
    localparam int WORD_W = 2 * AVG_W;

    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_TERM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd2;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd62259;
    localparam logic [EPS_W-1:0]   EPS_RESET   = 24'd1678;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd1;

    // Square root unit: 64-bit radicand, 32-bit root, two root bits per stage
    localparam int SQRT_RAD_W  = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

    // Divider: 64-bit dividend, 32-bit divisor, two quotient bits per stage
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS;

endpackage

/* src/adw_ifs.sv */
`timescale 1ns / 1ps

interface adw_grad_if;
    logic                            valid;
    logic                            ready;
    logic [adw_pkg::IDX_W-1:0]       weight_index;
    logic signed [adw_pkg::GRAD_W-1:0] gradient;

    modport source (output valid, output weight_index, output gradient, input ready);
    modport sink   (input valid, input weight_index, input gradient, output ready);
endinterface

interface adw_upd_if;
    logic                              valid;
    logic                              ready;
    logic [adw_pkg::IDX_W-1:0]         result_index;
    logic signed [adw_pkg::GRAD_W-1:0] weight_increment;

    modport source (output valid, output result_index, output weight_increment, input ready);
    modport sink   (input valid, input result_index, input weight_increment, output ready);
endinterface

interface adw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [adw_pkg::CFG_IDX_W-1:0]     index;
    logic [adw_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/adadelta_weight_update_top.sv */
`timescale 1ns / 1ps
// Throughput: one word per cycle while o_upd takes words and indexes differ from
//   every word still in flight; a word whose index is in flight waits until that
//   word writes back, set by the read-modify-write loop through the state RAM.
// Reset: synchronous, active low; then a clearing pass zeroes every entry of the
//   state RAM before the first gradient word is taken.
module adadelta_weight_update_top #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adw_grad_if.sink    i_grad,
    adw_upd_if.source   o_upd,
    adw_cfg_if.sink     i_cfg
);

    localparam int AW  = $clog2(NUM_WEIGHTS);
    localparam int XW  = AW + adw_pkg::IDX_W;
    localparam int LS  = adw_pkg::SQRT_STAGES;
    localparam int LD  = adw_pkg::DIV_STAGES;
    // Pipeline taps, one per stage after the accept edge
    localparam int NSB      = 6 + LS + LD;
    localparam int ST_READ  = 1;            // averages arrive from RAM
    localparam int ST_EG    = 2;            // new grad average ready
    localparam int ST_ROOT  = 2 + LS;       // both roots ready
    localparam int ST_PROD  = 3 + LS;       // |g|*sA and divisor registered
    localparam int ST_QUOT  = 3 + LS + LD;  // quotient ready
    localparam int ST_STEP  = 4 + LS + LD;  // d^2 and scaled step ready
    localparam int ST_LAST  = 5 + LS + LD;  // new step average, write back

    localparam int AVG_W  = adw_pkg::AVG_W;
    localparam int GRAD_W = adw_pkg::GRAD_W;

    typedef struct packed {
        logic                       inrange;
        logic                       neg;
        logic                       dz;
        logic [adw_pkg::IDX_W-1:0]  idx;
        logic [GRAD_W-1:0]          gmag;
        logic [AVG_W-1:0]           eg;
        logic [AVG_W-1:0]           ed;
    } t_side;

    // Blend an average toward a fresh square: (rho*old + (1-rho)*new) >> 16
    function automatic logic [AVG_W-1:0] f_blend(
        input logic [adw_pkg::DECAY_W-1:0] rho,
        input logic [AVG_W-1:0]            old_v,
        input logic [AVG_W-1:0]            new_v
    );
        logic [adw_pkg::DECAY_W:0] w;
        logic [AVG_W+16:0]         acc;
        logic [AVG_W:0]            v;
        w   = 17'h10000 - {1'b0, rho};
        acc = (AVG_W+17)'(old_v) * (AVG_W+17)'(rho) + (AVG_W+17)'(new_v) * (AVG_W+17)'(w);
        v   = acc[AVG_W+16:16];
        return (v > {1'b0, adw_pkg::AVG_MAX}) ? adw_pkg::AVG_MAX : v[AVG_W-1:0];
    endfunction

    // Configuration registers
    logic [adw_pkg::DECAY_W-1:0] r_decay;
    logic [adw_pkg::EPS_W-1:0]   r_eps;
    logic [adw_pkg::SCALE_W-1:0] r_scale;

    // Pipeline control and payload
    logic        r_v  [NSB];
    t_side       r_sb [NSB];
    logic        n_v  [NSB];
    t_side       n_sb [NSB];
    logic [AVG_W-1:0] r_g2;
    logic [adw_pkg::DIV_NUM_W-1:0] r_prod;
    logic [adw_pkg::DIV_DEN_W-1:0] r_dvs;
    logic [AVG_W-1:0] r_dsq;
    logic [43:0]      r_scaled;
    logic [GRAD_W-1:0] r_inc;

    // Output register
    logic                     r_out_v;
    logic [adw_pkg::IDX_W-1:0] r_out_idx;
    logic [GRAD_W-1:0]        r_out_inc;

    logic adv;
    logic hazard;
    logic accept;
    logic clr_busy;
    logic [adw_pkg::WORD_W-1:0] rd_data;
    logic [XW-1:0] in_idx_ext;
    logic [XW-1:0] wb_idx_ext;
    logic          in_inrange;
    logic          wr_en;
    logic [GRAD_W-1:0] in_gmag;

    logic [adw_pkg::SQRT_RAD_W-1:0] rad_a;
    logic [adw_pkg::SQRT_RAD_W-1:0] rad_b;
    logic [adw_pkg::ROOT_W-1:0]     root_a;
    logic [adw_pkg::ROOT_W-1:0]     root_b;
    logic [AVG_W:0]                 sum_a;
    logic [AVG_W:0]                 sum_b;
    logic [adw_pkg::DIV_NUM_W-1:0]  quot;

    logic [adw_pkg::DIV_NUM_W-1:0]  m;
    logic [48:0]                    m_clip;
    logic [AVG_W-1:0]               n_dsq;
    logic [43:0]                    n_scaled;
    logic [GRAD_W-1:0]              n_inc;
    logic [63:0]                    g_sq;
    logic [55:0]                    m_sq;
    logic [59:0]                    m_scaled;

    // The whole pipe advances unless a finished word is held at the output
    assign adv = !r_out_v || o_upd.ready;

    assign in_idx_ext = XW'(i_grad.weight_index);
    assign in_inrange = in_idx_ext < XW'(NUM_WEIGHTS);
    assign in_gmag    = i_grad.gradient[GRAD_W-1] ? (~i_grad.gradient + 1'b1)
                                                  : i_grad.gradient;

    // Interlock: hold a word whose entry is still being worked on
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < NSB; k++) begin
            if (r_v[k] && r_sb[k].inrange && (r_sb[k].idx == i_grad.weight_index)) begin
                hazard = 1'b1;
            end
        end
    end

    assign i_grad.ready = adv && !clr_busy && !hazard;
    assign accept       = i_grad.valid && i_grad.ready;
    assign i_cfg.ready  = 1'b1;

    // Square-root operands: (avg + eps) << 14
    assign sum_a = {1'b0, r_sb[ST_EG].ed} + (AVG_W+1)'(r_eps);
    assign sum_b = {1'b0, r_sb[ST_EG].eg} + (AVG_W+1)'(r_eps);
    assign rad_a = {1'b0, sum_a, 14'b0};
    assign rad_b = {1'b0, sum_b, 14'b0};

    // Step magnitude, its square and the scaled increment
    assign g_sq     = 64'(r_sb[0].gmag) * 64'(r_sb[0].gmag);
    assign m        = r_sb[ST_QUOT].dz ? '0 : quot;
    assign m_clip   = (m > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : m[48:0];
    assign m_sq     = 56'(m[27:0]) * 56'(m[27:0]);
    assign m_scaled = 60'(m_clip) * 60'(r_scale);
    assign n_dsq    = (|m[63:28]) ? adw_pkg::AVG_MAX : m_sq[55:8];
    assign n_scaled = m_scaled[59:16];

    // Truncate toward zero and saturate to signed 32 bits
    always_comb begin
        logic [GRAD_W-1:0] mag;
        if (r_sb[ST_STEP].neg) begin
            mag   = (r_scaled > 44'h8000_0000) ? 32'h8000_0000 : r_scaled[GRAD_W-1:0];
            n_inc = 32'h0 - mag;
        end else begin
            mag   = (r_scaled > 44'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_scaled[GRAD_W-1:0];
            n_inc = mag;
        end
    end

    // Next values of the pipeline taps
    always_comb begin
        n_v[0]          = accept;
        n_sb[0].inrange = in_inrange;
        n_sb[0].neg     = i_grad.gradient[GRAD_W-1];
        n_sb[0].dz      = 1'b0;
        n_sb[0].idx     = i_grad.weight_index;
        n_sb[0].gmag    = in_gmag;
        n_sb[0].eg      = '0;
        n_sb[0].ed      = '0;
        for (int k = 1; k < NSB; k++) begin
            n_v[k]  = r_v[k-1];
            n_sb[k] = r_sb[k-1];
        end
        n_sb[ST_READ].eg = rd_data[adw_pkg::WORD_W-1:AVG_W];
        n_sb[ST_READ].ed = rd_data[AVG_W-1:0];
        n_sb[ST_EG].eg   = f_blend(r_decay, r_sb[ST_READ].eg, r_g2);
        n_sb[ST_PROD].dz = (root_b == '0);
        n_sb[ST_LAST].ed = f_blend(r_decay, r_sb[ST_STEP].ed, r_dsq);
    end

    assign wb_idx_ext = XW'(r_sb[ST_LAST].idx);
    assign wr_en      = adv && r_v[ST_LAST] && r_sb[ST_LAST].inrange;

    adw_state_mem #(
        .DEPTH (NUM_WEIGHTS),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (in_idx_ext[AW-1:0]),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wb_idx_ext[AW-1:0]),
        .i_wr_data  ({r_sb[ST_LAST].eg, r_sb[ST_LAST].ed}),
        .o_clr_busy (clr_busy)
    );

    adw_sqrt_pipe u_sqrt_a (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_radicand (rad_a),
        .o_root     (root_a)
    );

    adw_sqrt_pipe u_sqrt_b (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_radicand (rad_b),
        .o_root     (root_b)
    );

    adw_div_pipe u_div (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (r_prod),
        .i_divisor  (r_dvs),
        .o_quot     (quot)
    );

    // Control: valid bits, output valid, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSB; k++) begin
                r_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
            r_decay <= adw_pkg::DECAY_RESET;
            r_eps   <= adw_pkg::EPS_RESET;
            r_scale <= adw_pkg::SCALE_RESET;
        end else begin
            if (adv) begin
                r_v     <= n_v;
                r_out_v <= r_v[ST_LAST];
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    adw_pkg::CFG_DECAY_RATE:   r_decay <= i_cfg.data[adw_pkg::DECAY_W-1:0];
                    adw_pkg::CFG_EPSILON_TERM: r_eps   <= i_cfg.data[adw_pkg::EPS_W-1:0];
                    adw_pkg::CFG_OUTPUT_SCALE: r_scale <= i_cfg.data[adw_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload: advance with the pipe
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb     <= n_sb;
            r_g2     <= (|g_sq[63:56]) ? adw_pkg::AVG_MAX : g_sq[55:8];
            r_prod   <= 64'(r_sb[ST_ROOT].gmag) * 64'(root_a);
            r_dvs    <= root_b;
            r_dsq    <= n_dsq;
            r_scaled <= n_scaled;
            r_inc    <= n_inc;
            r_out_idx <= r_sb[ST_LAST].idx;
            r_out_inc <= r_sb[ST_LAST].inrange ? r_inc : '0;
        end
    end

    assign o_upd.valid            = r_out_v;
    assign o_upd.result_index     = r_out_idx;
    assign o_upd.weight_increment = r_out_inc;

endmodule

/* src/adw_state_mem.sv */
`timescale 1ns / 1ps

module adw_state_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [adw_pkg::WORD_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [adw_pkg::WORD_W-1:0] i_wr_data,
    output logic                       o_clr_busy
);

    logic [adw_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [adw_pkg::WORD_W-1:0] r_rd_data;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_clr_busy;

    // Sweep zeros through every entry after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

/* src/adw_sqrt_pipe.sv */
`timescale 1ns / 1ps

module adw_sqrt_pipe (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [adw_pkg::SQRT_RAD_W-1:0] i_radicand,
    output logic [adw_pkg::ROOT_W-1:0]     o_root
);

    localparam int NS = adw_pkg::SQRT_STAGES;
    localparam int XW = adw_pkg::SQRT_RAD_W;
    localparam int QW = adw_pkg::ROOT_W;
    localparam int RW = QW + 4;

    logic [XW-1:0] r_rad  [NS];
    logic [RW-1:0] r_rem  [NS];
    logic [QW-1:0] r_root [NS];
    logic [XW-1:0] n_rad  [NS];
    logic [RW-1:0] n_rem  [NS];
    logic [QW-1:0] n_root [NS];

    // Restoring square root, two root bits per stage
    always_comb begin
        logic [XW-1:0] rad;
        logic [RW-1:0] rem;
        logic [QW-1:0] root;
        logic [RW-1:0] trial;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                rad  = i_radicand;
                rem  = '0;
                root = '0;
            end else begin
                rad  = r_rad[s-1];
                rem  = r_rem[s-1];
                root = r_root[s-1];
            end
            for (int j = 0; j < adw_pkg::SQRT_STEPS; j++) begin
                rem   = {rem[RW-3:0], rad[XW-1:XW-2]};
                rad   = {rad[XW-3:0], 2'b00};
                trial = RW'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[QW-2:0], 1'b1};
                end else begin
                    root = {root[QW-2:0], 1'b0};
                end
            end
            n_rad[s]  = rad;
            n_rem[s]  = rem;
            n_root[s] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_root = r_root[NS-1];

endmodule

/* src/adw_div_pipe.sv */
`timescale 1ns / 1ps

module adw_div_pipe (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [adw_pkg::DIV_NUM_W-1:0] i_dividend,
    input  logic [adw_pkg::DIV_DEN_W-1:0] i_divisor,
    output logic [adw_pkg::DIV_NUM_W-1:0] o_quot
);

    localparam int NS = adw_pkg::DIV_STAGES;
    localparam int NW = adw_pkg::DIV_NUM_W;
    localparam int DW = adw_pkg::DIV_DEN_W;
    localparam int AW = NW + DW;

    // {remainder, dividend bits left / quotient bits so far}
    logic [AW-1:0] r_acc [NS];
    logic [DW-1:0] r_dvs [NS];
    logic [AW-1:0] n_acc [NS];
    logic [DW-1:0] n_dvs [NS];

    always_comb begin
        logic [AW-1:0] acc;
        logic [DW-1:0] dvs;
        logic [AW:0]   t;
        logic [DW:0]   hi;
        for (int s = 0; s < NS; s++) begin
            if (s == 0) begin
                acc = AW'(i_dividend);
                dvs = i_divisor;
            end else begin
                acc = r_acc[s-1];
                dvs = r_dvs[s-1];
            end
            for (int j = 0; j < adw_pkg::DIV_STEPS; j++) begin
                t  = {acc, 1'b0};
                hi = t[AW:NW];
                if (hi >= {1'b0, dvs}) begin
                    hi   = hi - {1'b0, dvs};
                    t[0] = 1'b1;
                end
                acc = {hi[DW-1:0], t[NW-1:0]};
            end
            n_acc[s] = acc;
            n_dvs[s] = dvs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_dvs <= n_dvs;
        end
    end

    assign o_quot = r_acc[NS-1][NW-1:0];

endmodule
